### src/aifp_pkg.sv
// Shared types and constants of the ASCII integer field parser.
package aifp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned BaseW  = 5;

  typedef logic [7:0]        char_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [BaseW-1:0]  base_t;
  typedef logic [7:0]        cfg_index_t;
  typedef logic [15:0]       cfg_data_t;

  // Configuration register indexes
  localparam cfg_index_t CFG_BASE_MODE   = 8'd0;
  localparam cfg_index_t CFG_MAX_WIDTH   = 8'd1;
  localparam cfg_index_t CFG_RESULT_SIZE = 8'd2;
  localparam cfg_index_t CFG_IS_UNSIGNED = 8'd3;

  // base_mode codes
  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // result_size codes
  localparam logic [2:0] SIZE_8  = 3'd0;
  localparam logic [2:0] SIZE_16 = 3'd1;
  localparam logic [2:0] SIZE_32 = 3'd2;

  // Active radix; BASE_NONE means not yet resolved
  localparam base_t BASE_NONE = 5'd0;
  localparam base_t BASE_OCT  = 5'd8;
  localparam base_t BASE_DEC  = 5'd10;
  localparam base_t BASE_HEX  = 5'd16;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_X_LO  = 8'h78;
  localparam char_t CH_X_UP  = 8'h58;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;

  typedef enum logic [3:0] {
    PH_WS     = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   neg;
    value_t acc;
    base_t  base;
    count_t counted;
    count_t consumed;
    logic   seen;
  } parse_state_t;

  // Unformatted result of one conversion
  typedef struct packed {
    value_t acc;
    logic   neg;
    logic   ok;
    count_t consumed;
    logic   returned;
  } raw_res_t;

  localparam parse_state_t STATE_IDLE = '{
    phase:    PH_WS,
    neg:      1'b0,
    acc:      '0,
    base:     BASE_NONE,
    counted:  '0,
    consumed: '0,
    seen:     1'b0
  };

endpackage

### src/aifp_if.sv
// Handshake channels of the ASCII integer field parser.
interface aifp_in_if;
  logic             valid;
  logic             ready;
  aifp_pkg::char_t  ch;
  logic             end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface aifp_out_if;
  logic             valid;
  logic             ready;
  aifp_pkg::value_t value;
  logic             failed;
  aifp_pkg::count_t chars_consumed;
  logic             char_returned;

  modport source (output valid, output value, output failed, output chars_consumed,
                  output char_returned, input ready);
  modport sink   (input valid, input value, input failed, input chars_consumed,
                  input char_returned, output ready);
endinterface

interface aifp_cfg_if;
  logic                 valid;
  logic                 ready;
  aifp_pkg::cfg_index_t index;
  aifp_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/aifp_step.sv
// One-character parse step: next conversion state and the raw result it causes.
module aifp_step (
  input  aifp_pkg::parse_state_t st_i,
  input  aifp_pkg::char_t        ch_i,
  input  logic                   eoi_i,
  input  logic [1:0]             base_mode_i,
  input  aifp_pkg::count_t       max_width_i,
  output aifp_pkg::parse_state_t st_o,
  output logic                   emit_o,
  output aifp_pkg::raw_res_t     res_o
);

  aifp_pkg::parse_state_t st;
  aifp_pkg::base_t        mode_base;
  aifp_pkg::value_t       acc_scaled;
  logic                   is_ws;
  logic                   is_sign;
  logic                   is_x;
  logic                   dig_vld;
  logic [3:0]             dig;
  logic                   emit;
  logic                   ret;
  logic                   done;

  function automatic aifp_pkg::count_t sat_inc(aifp_pkg::count_t v);
    sat_inc = (v == '1) ? v : v + aifp_pkg::count_t'(1);
  endfunction

  assign is_ws   = (ch_i == aifp_pkg::CH_SPACE) ||
                   ((ch_i >= aifp_pkg::CH_TAB) && (ch_i <= aifp_pkg::CH_CR));
  assign is_sign = (ch_i == aifp_pkg::CH_MINUS) || (ch_i == aifp_pkg::CH_PLUS);
  assign is_x    = (ch_i == aifp_pkg::CH_X_LO) || (ch_i == aifp_pkg::CH_X_UP);

  always_comb begin
    dig_vld = 1'b1;
    dig     = 4'd0;
    if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      dig = 4'(ch_i - 8'h30);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h66) begin
      dig = 4'(ch_i - 8'h57);
    end else if (ch_i >= 8'h41 && ch_i <= 8'h46) begin
      dig = 4'(ch_i - 8'h37);
    end else begin
      dig_vld = 1'b0;
    end
  end

  always_comb begin
    unique case (base_mode_i)
      aifp_pkg::MODE_OCT: mode_base = aifp_pkg::BASE_OCT;
      aifp_pkg::MODE_DEC: mode_base = aifp_pkg::BASE_DEC;
      aifp_pkg::MODE_HEX: mode_base = aifp_pkg::BASE_HEX;
      default:            mode_base = aifp_pkg::BASE_NONE;
    endcase
  end

  always_comb begin
    st   = st_i;
    emit = 1'b0;
    ret  = 1'b0;
    done = 1'b0;

    if (eoi_i) begin
      emit = 1'b1;
      done = 1'b1;
    end

    if (!done && st.phase == aifp_pkg::PH_WS) begin
      if (is_ws) begin
        st.consumed = sat_inc(st.consumed);
        done        = 1'b1;
      end else begin
        st.base  = mode_base;
        st.phase = aifp_pkg::PH_PREFIX;
        if (is_sign) begin
          st.neg      = (ch_i == aifp_pkg::CH_MINUS);
          st.consumed = sat_inc(st.consumed);
          st.counted  = sat_inc(st.counted);
          emit        = (max_width_i != '0) && (st.counted >= max_width_i);
          done        = 1'b1;
        end
      end
    end

    if (!done && st.phase == aifp_pkg::PH_PREFIX) begin
      if (is_ws) begin
        // whitespace right after the sign ends the field
        emit = 1'b1;
        ret  = 1'b1;
        done = 1'b1;
      end else if (ch_i == aifp_pkg::CH_ZERO) begin
        st.consumed = sat_inc(st.consumed);
        st.counted  = sat_inc(st.counted);
        st.phase    = aifp_pkg::PH_ZERO;
        emit        = (max_width_i != '0) && (st.counted >= max_width_i);
        done        = 1'b1;
      end else begin
        if (st.base == aifp_pkg::BASE_NONE) begin
          st.base = aifp_pkg::BASE_DEC;
        end
        st.phase = aifp_pkg::PH_DIGITS;
      end
    end

    if (!done && st.phase == aifp_pkg::PH_ZERO) begin
      if (is_x && (st.base == aifp_pkg::BASE_NONE || st.base == aifp_pkg::BASE_HEX)) begin
        st.base     = aifp_pkg::BASE_HEX;
        st.consumed = sat_inc(st.consumed);
        st.counted  = sat_inc(st.counted);
        st.phase    = aifp_pkg::PH_DIGITS;
        emit        = (max_width_i != '0) && (st.counted >= max_width_i);
        done        = 1'b1;
      end else begin
        // the leading zero stands as a parsed digit
        if (!is_x && st.base == aifp_pkg::BASE_NONE) begin
          st.base = aifp_pkg::BASE_OCT;
        end
        st.seen  = 1'b1;
        st.phase = aifp_pkg::PH_DIGITS;
      end
    end

    if (!done) begin
      if (!dig_vld || st.base == aifp_pkg::BASE_NONE ||
          {1'b0, dig} >= st.base) begin
        emit = 1'b1;
        ret  = 1'b1;
      end else begin
        st.acc      = acc_scaled + aifp_pkg::value_t'(dig);
        st.seen     = 1'b1;
        st.consumed = sat_inc(st.consumed);
        st.counted  = sat_inc(st.counted);
        emit        = (max_width_i != '0) && (st.counted >= max_width_i);
      end
    end
  end

  // Radix multiply as shift and add
  always_comb begin
    case (st_i.phase == aifp_pkg::PH_DIGITS ? st_i.base :
          (st_i.phase == aifp_pkg::PH_ZERO && st_i.base == aifp_pkg::BASE_NONE) ?
          aifp_pkg::BASE_OCT :
          (st_i.phase == aifp_pkg::PH_ZERO) ? st_i.base :
          (st_i.base == aifp_pkg::BASE_NONE) ? aifp_pkg::BASE_DEC : st_i.base)
      aifp_pkg::BASE_HEX: acc_scaled = st_i.acc << 4;
      aifp_pkg::BASE_DEC: acc_scaled = (st_i.acc << 3) + (st_i.acc << 1);
      default:            acc_scaled = st_i.acc << 3;
    endcase
  end

  always_comb begin
    res_o.acc      = st.acc;
    res_o.neg      = st.neg;
    res_o.ok       = st.seen || (st.phase == aifp_pkg::PH_ZERO);
    res_o.consumed = st.consumed;
    res_o.returned = ret;
    st_o           = emit ? aifp_pkg::STATE_IDLE : st;
  end

  assign emit_o = emit;

endmodule

### src/aifp_format.sv
// Result formatting: sign, truncation to the target size and extension.
module aifp_format (
  input  aifp_pkg::raw_res_t raw_i,
  input  logic [2:0]         result_size_i,
  input  logic               is_unsigned_i,
  output aifp_pkg::value_t   value_o,
  output logic               failed_o,
  output aifp_pkg::count_t   chars_consumed_o,
  output logic               char_returned_o
);

  aifp_pkg::value_t signed_val;
  aifp_pkg::value_t sized_val;

  assign signed_val = raw_i.neg ? (aifp_pkg::value_t'(0) - raw_i.acc) : raw_i.acc;

  always_comb begin
    case (result_size_i)
      aifp_pkg::SIZE_8: begin
        sized_val = is_unsigned_i ? {56'd0, signed_val[7:0]}
                                  : {{56{signed_val[7]}}, signed_val[7:0]};
      end
      aifp_pkg::SIZE_16: begin
        sized_val = is_unsigned_i ? {48'd0, signed_val[15:0]}
                                  : {{48{signed_val[15]}}, signed_val[15:0]};
      end
      aifp_pkg::SIZE_32: begin
        sized_val = is_unsigned_i ? {32'd0, signed_val[31:0]}
                                  : {{32{signed_val[31]}}, signed_val[31:0]};
      end
      default: sized_val = signed_val;
    endcase
  end

  assign value_o          = raw_i.ok ? sized_val : '0;
  assign failed_o         = !raw_i.ok;
  assign chars_consumed_o = raw_i.consumed;
  assign char_returned_o  = raw_i.returned;

endmodule

### src/ascii_integer_field_parser.sv
// Top level of the ASCII integer field parser.
// Parses one scanf-style integer from a stream of ASCII characters, one character
// per item, and gives one result item per conversion (value, failed flag, count of
// characters consumed, and whether the last character must be presented again).
// Throughput is one character per clock cycle while the result side keeps up. A result
// item is offered from the output register once the character that ends the conversion
// is accepted and has passed the parse step into the raw result register, then the format
// stage into the output register. A held result stalls the input once the raw
// result register is also full. The rate is set by the combinational parse step, whose
// state feeds the next character. Write configuration only while no conversion is open.
module ascii_integer_field_parser (
  input  logic clk_i,
  input  logic rst_ni,
  aifp_in_if.sink    in_i,
  aifp_out_if.source out_o,
  aifp_cfg_if.sink   cfg_i
);

  // Configuration
  logic [1:0]       base_mode_q;
  aifp_pkg::count_t max_width_q;
  logic [2:0]       result_size_q;
  logic             is_unsigned_q;

  // Input register
  logic             in_valid_q;
  aifp_pkg::char_t  in_ch_q;
  logic             in_eoi_q;

  // Parse state and raw result register
  aifp_pkg::parse_state_t st_q;
  aifp_pkg::parse_state_t st_d;
  logic                   emit;
  aifp_pkg::raw_res_t     raw_d;
  aifp_pkg::raw_res_t     raw_q;
  logic                   raw_valid_q;

  // Output register
  logic             out_valid_q;
  aifp_pkg::value_t out_value_q;
  aifp_pkg::value_t out_value_d;
  logic             out_failed_q;
  logic             out_failed_d;
  aifp_pkg::count_t out_chars_q;
  aifp_pkg::count_t out_chars_d;
  logic             out_ret_q;
  logic             out_ret_d;

  logic out_free;
  logic raw_adv;
  logic raw_free;
  logic step_fire;

  assign out_free  = !out_valid_q || out_o.ready;
  assign raw_adv   = raw_valid_q && out_free;
  assign raw_free  = !raw_valid_q || raw_adv;
  assign step_fire = in_valid_q && raw_free;
  assign in_i.ready = !in_valid_q || step_fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q   <= aifp_pkg::MODE_DEC;
      max_width_q   <= '0;
      result_size_q <= aifp_pkg::SIZE_32;
      is_unsigned_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        aifp_pkg::CFG_BASE_MODE:   base_mode_q   <= cfg_i.data[1:0];
        aifp_pkg::CFG_MAX_WIDTH:   max_width_q   <= cfg_i.data[aifp_pkg::CountW-1:0];
        aifp_pkg::CFG_RESULT_SIZE: result_size_q <= cfg_i.data[2:0];
        aifp_pkg::CFG_IS_UNSIGNED: is_unsigned_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q  <= in_i.ch;
      in_eoi_q <= in_i.end_of_input;
    end
  end

  aifp_step u_step (
    .st_i        (st_q),
    .ch_i        (in_ch_q),
    .eoi_i       (in_eoi_q),
    .base_mode_i (base_mode_q),
    .max_width_i (max_width_q),
    .st_o        (st_d),
    .emit_o      (emit),
    .res_o       (raw_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= aifp_pkg::STATE_IDLE;
      raw_valid_q <= 1'b0;
    end else begin
      if (step_fire) begin
        st_q <= st_d;
      end
      if (raw_free) begin
        raw_valid_q <= step_fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      raw_q <= raw_d;
    end
  end

  aifp_format u_format (
    .raw_i            (raw_q),
    .result_size_i    (result_size_q),
    .is_unsigned_i    (is_unsigned_q),
    .value_o          (out_value_d),
    .failed_o         (out_failed_d),
    .chars_consumed_o (out_chars_d),
    .char_returned_o  (out_ret_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= raw_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_adv) begin
      out_value_q  <= out_value_d;
      out_failed_q <= out_failed_d;
      out_chars_q  <= out_chars_d;
      out_ret_q    <= out_ret_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = out_value_q;
  assign out_o.failed         = out_failed_q;
  assign out_o.chars_consumed = out_chars_q;
  assign out_o.char_returned  = out_ret_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_failed_q |-> out_value_q == '0)
    else $error("failed result carries a nonzero value");

  a_ok_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_failed_q |-> out_chars_q != '0)
    else $error("parsed result with no character consumed");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && emit |=> st_q.phase == aifp_pkg::PH_WS && st_q.consumed == '0)
    else $error("parser did not re-arm after a result");

  a_seen_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.seen |-> st_q.phase == aifp_pkg::PH_DIGITS)
    else $error("digit seen outside the digit phase");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ASCII integer field parser with its own parse predictor.
module tb;
  import aifp_pkg::*;

  localparam int unsigned MAX_GAP        = 12;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_CHARS   = 960;
  localparam int unsigned FIELDS_PER_SET = 8;
  localparam int unsigned LONG_SPACES    = 10;
  localparam int unsigned LONG_DIGITS    = 40;
  localparam int unsigned NOT_A_DIGIT    = 99;
  localparam cfg_index_t  CFG_NONE       = 8'hFF;
  localparam logic [2:0]  SIZE_64        = 3'd3;
  localparam logic [2:0]  SIZE_UNUSED    = 3'd7;

  typedef struct packed {
    value_t value;
    logic   failed;
    count_t consumed;
    logic   returned;
  } conv_res_t;

  typedef enum logic [1:0] {ROW_CHAR, ROW_EOI, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    cfg_index_t idx;
    cfg_data_t  data;
    logic       typed;
    conv_res_t  exp;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  aifp_in_if  char_ch ();
  aifp_out_if conv_ch ();
  aifp_cfg_if reg_ch ();

  ascii_integer_field_parser DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (char_ch),
    .out_o  (conv_ch),
    .cfg_i  (reg_ch)
  );

  // Predictor copy of the parse state and the registers
  parse_state_t scan_st   = STATE_IDLE;
  logic [1:0]   mode_reg  = MODE_DEC;
  count_t       width_reg = '0;
  logic [2:0]   size_reg  = SIZE_32;
  logic         uns_reg   = 1'b0;

  conv_res_t   pending_q[$];
  stim_row_t   script[$];
  logic        row_typed = 1'b0;
  conv_res_t   row_exp   = '0;
  logic        pace_on   = 1'b1;
  int unsigned errors = 0, chars_sent = 0, reg_writes = 0, settings = 0;
  int unsigned conversions = 0, failed_parses = 0, idle_cycles = 0;

  function automatic logic is_space(input char_t c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned digit_value(input char_t c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return c - CH_ZERO;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic char_t digit_char(input int unsigned d);
    char_t letter;
    if (d < 10) return CH_ZERO + char_t'(d);
    letter = $urandom_range(0, 1) ? "a" : "A";
    return letter + char_t'(d - 10);
  endfunction

  function automatic void bump(input logic counts);
    if (scan_st.consumed != '1) scan_st.consumed++;
    if (counts && scan_st.counted != '1) scan_st.counted++;
  endfunction

  // Apply sign, size and extension, then re-arm for the next field
  function automatic conv_res_t close_field(input logic returned);
    conv_res_t   r;
    logic        ok;
    value_t      v;
    value_t      m;
    int unsigned bits;
    ok = scan_st.seen || scan_st.phase == PH_ZERO;
    v  = '0;
    if (ok) begin
      v = scan_st.neg ? -scan_st.acc : scan_st.acc;
      if (size_reg <= SIZE_32) begin
        bits = 8 << size_reg;
        m    = (value_t'(1) << bits) - value_t'(1);
        v   &= m;
        if (!uns_reg && v[bits-1]) v |= ~m;
      end
    end
    r       = '{v, !ok, scan_st.consumed, returned};
    scan_st = STATE_IDLE;
    return r;
  endfunction

  function automatic logic at_width(output conv_res_t r);
    r = '0;
    if (width_reg != '0 && scan_st.counted >= width_reg) begin
      r = close_field(1'b0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parse by one item; return 1 when it closes a field
  function automatic logic scan_char(input char_t c, input logic eoi, output conv_res_t r);
    int unsigned d;
    r = '0;
    if (eoi) begin
      r = close_field(1'b0);
      return 1'b1;
    end
    if (scan_st.phase == PH_WS) begin
      if (is_space(c)) begin
        bump(1'b0);
        return 1'b0;
      end
      case (mode_reg)
        MODE_OCT: scan_st.base = BASE_OCT;
        MODE_DEC: scan_st.base = BASE_DEC;
        MODE_HEX: scan_st.base = BASE_HEX;
        default:  scan_st.base = BASE_NONE;
      endcase
      scan_st.phase = PH_PREFIX;
      if (c == CH_MINUS || c == CH_PLUS) begin
        scan_st.neg = (c == CH_MINUS);
        bump(1'b1);
        return at_width(r);
      end
    end
    if (scan_st.phase == PH_PREFIX) begin
      if (is_space(c)) begin
        r = close_field(1'b1);
        return 1'b1;
      end
      if (c == CH_ZERO) begin
        bump(1'b1);
        scan_st.phase = PH_ZERO;
        return at_width(r);
      end
      if (scan_st.base == BASE_NONE) scan_st.base = BASE_DEC;
      scan_st.phase = PH_DIGITS;
    end
    if (scan_st.phase == PH_ZERO) begin
      if (c == CH_X_LO || c == CH_X_UP) begin
        if (scan_st.base == BASE_NONE || scan_st.base == BASE_HEX) begin
          scan_st.base  = BASE_HEX;
          scan_st.phase = PH_DIGITS;
          bump(1'b1);
          return at_width(r);
        end
      end else if (scan_st.base == BASE_NONE) begin
        scan_st.base = BASE_OCT;
      end
      scan_st.seen  = 1'b1;
      scan_st.phase = PH_DIGITS;
    end
    d = digit_value(c);
    if (scan_st.base == BASE_NONE || d >= scan_st.base) begin
      r = close_field(1'b1);
      return 1'b1;
    end
    scan_st.acc  = scan_st.acc * scan_st.base + value_t'(d);
    scan_st.seen = 1'b1;
    bump(1'b1);
    return at_width(r);
  endfunction

  // Check results, then predict from the item accepted at this edge
  always @(posedge clk) begin : monitor
    conv_res_t want;
    conv_res_t got_res;
    logic      produced;
    if (conv_ch.valid && conv_ch.ready) begin
      conversions++;
      if (conv_ch.failed) failed_parses++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no field pending: value %h failed %b consumed %0d returned %b",
                 $time, conv_ch.value, conv_ch.failed, conv_ch.chars_consumed,
                 conv_ch.char_returned);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (conv_ch.value !== want.value) begin
          $display("%0t: value expected %h, got %h", $time, want.value, conv_ch.value);
          errors++;
        end
        if (conv_ch.failed !== want.failed) begin
          $display("%0t: failed expected %b, got %b", $time, want.failed, conv_ch.failed);
          errors++;
        end
        if (conv_ch.chars_consumed !== want.consumed) begin
          $display("%0t: chars_consumed expected %0d, got %0d", $time, want.consumed,
                   conv_ch.chars_consumed);
          errors++;
        end
        if (conv_ch.char_returned !== want.returned) begin
          $display("%0t: char_returned expected %b, got %b", $time, want.returned,
                   conv_ch.char_returned);
          errors++;
        end
      end
    end
    if (char_ch.valid && char_ch.ready) begin
      produced = scan_char(char_ch.ch, char_ch.end_of_input, got_res);
      if (row_typed) pending_q.push_back(row_exp);
      else if (produced) pending_q.push_back(got_res);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (char_ch.valid && char_ch.ready) || (conv_ch.valid && conv_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned stall;
    conv_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pace_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk);
      if (stall != 0) begin
        conv_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      conv_ch.ready = 1'b1;
      do @(posedge clk); while (!conv_ch.valid);
    end
  end

  task automatic send_item(input char_t c, input logic eoi, input logic typed,
                           input conv_res_t exp);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap != 0) begin
      char_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_ch.valid        = 1'b1;
    char_ch.ch           = c;
    char_ch.end_of_input = eoi;
    row_typed            = typed;
    row_exp              = exp;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  task automatic send_char(input char_t c);
    send_item(c, 1'b0, 1'b0, '0);
  endtask

  task automatic send_eoi();
    send_item(char_t'($urandom), 1'b1, 1'b0, '0);
  endtask

  // Drop the input, drain all results and let the pipeline empty
  task automatic settle();
    @(negedge clk);
    char_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    @(negedge clk);
    reg_ch.valid = 1'b1;
    reg_ch.index = idx;
    reg_ch.data  = data;
    do @(posedge clk); while (!reg_ch.ready);
    case (idx)
      CFG_BASE_MODE:   mode_reg  = data[1:0];
      CFG_MAX_WIDTH:   width_reg = data;
      CFG_RESULT_SIZE: size_reg  = data[2:0];
      CFG_IS_UNSIGNED: uns_reg   = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    reg_ch.valid = 1'b0;
  endtask

  task automatic set_config(input logic [1:0] mode, input count_t width,
                            input logic [2:0] size, input logic uns);
    cfg_data_t junk;
    junk = cfg_data_t'($urandom);
    settle();
    write_reg(CFG_BASE_MODE, {junk[13:0], mode});
    write_reg(CFG_MAX_WIDTH, width);
    write_reg(CFG_RESULT_SIZE, {junk[12:0], size});
    write_reg(CFG_IS_UNSIGNED, {junk[14:0], uns});
    write_reg(CFG_NONE, junk);
    settings++;
  endtask

  // One field: mostly well formed with random content, some plain noise
  task automatic random_field();
    int unsigned pick, len, radix, d;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0) send_eoi();
        else send_char(char_t'($urandom));
      end
      return;
    end
    len = $urandom_range(0, 3);
    repeat (len) begin
      if ($urandom_range(0, 5) == 0) send_char(CH_SPACE);
      else send_char(char_t'($urandom_range(CH_TAB, CH_CR)));
    end
    case ($urandom_range(0, 2))
      1:       send_char(CH_PLUS);
      2:       send_char(CH_MINUS);
      default: ;
    endcase
    radix = mode_reg == MODE_OCT ? 8 : mode_reg == MODE_HEX ? 16 : 10;
    pick  = $urandom_range(0, 11);
    if (pick < 2) begin
      send_char(CH_ZERO);
      send_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
      if (mode_reg == MODE_AUTO) radix = 16;
    end else if (pick < 5) begin
      send_char(CH_ZERO);
      if (mode_reg == MODE_AUTO) radix = 8;
    end
    // Long runs can wrap the accumulator
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
    repeat (len) begin
      d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(0, radix - 1);
      send_char(digit_char(d));
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) send_eoi();
    else if (pick < 6) send_char(char_t'($urandom_range(CH_TAB, CH_CR)));
    else send_char(char_t'($urandom));
  endtask

  initial begin : stimulus
    int unsigned set_no, first_random;
    count_t      width;
    char_ch.valid        = 1'b0;
    char_ch.ch           = '0;
    char_ch.end_of_input = 1'b0;
    reg_ch.valid         = 1'b0;
    reg_ch.index         = CFG_BASE_MODE;
    reg_ch.data          = '0;

    // Reset settings: decimal, no width limit, 32-bit signed
    script.push_back('{ROW_EOI,  CFG_NONE, 16'h00FF, 1'b1, '{64'd0, 1'b1, 16'd0, 1'b0}});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_SPACE, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_MINUS, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "5",      1'b0, '0});
    script.push_back('{ROW_EOI,  CFG_NONE, 16'h0000, 1'b1,
                       '{64'hFFFF_FFFF_FFFF_FFFB, 1'b0, 16'd3, 1'b0}});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_ZERO,  1'b0, '0});
    script.push_back('{ROW_EOI,  CFG_NONE, 16'h0000, 1'b1, '{64'd0, 1'b0, 16'd1, 1'b0}});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_ZERO,  1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_X_LO,  1'b1, '{64'd0, 1'b0, 16'd1, 1'b1}});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_MINUS, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_TAB,   1'b1, '{64'd0, 1'b1, 16'd1, 1'b1}});
    // Bare hex prefix fails
    script.push_back('{ROW_CFG,  CFG_BASE_MODE, MODE_HEX, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_ZERO,  1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_X_UP,  1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "g",      1'b1, '{64'd0, 1'b1, 16'd2, 1'b1}});
    script.push_back('{ROW_CFG,  CFG_RESULT_SIZE, SIZE_8, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "f",      1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "F",      1'b0, '0});
    script.push_back('{ROW_EOI,  CFG_NONE, 16'h0000, 1'b1, '{'1, 1'b0, 16'd2, 1'b0}});
    script.push_back('{ROW_CFG,  CFG_IS_UNSIGNED, 16'd1, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_MINUS, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "1",      1'b0, '0});
    script.push_back('{ROW_EOI,  CFG_NONE, 16'h0000, 1'b1, '{64'hFF, 1'b0, 16'd2, 1'b0}});
    // Width of two closes the field on the second counted character
    script.push_back('{ROW_CFG,  CFG_BASE_MODE, MODE_DEC, 1'b0, '0});
    script.push_back('{ROW_CFG,  CFG_MAX_WIDTH, 16'd2,    1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "1",      1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "2",      1'b1, '{64'd12, 1'b0, 16'd2, 1'b0}});
    script.push_back('{ROW_CFG,  CFG_RESULT_SIZE, SIZE_UNUSED, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, CH_MINUS, 1'b0, '0});
    script.push_back('{ROW_CHAR, CFG_NONE, "1",      1'b1, '{'1, 1'b0, 16'd2, 1'b0}});

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(script[i].idx, script[i].data);
        end
        ROW_EOI: send_item(script[i].data[7:0], 1'b1, script[i].typed, script[i].exp);
        default: send_item(script[i].data[7:0], 1'b0, script[i].typed, script[i].exp);
      endcase
    end

    // Walk all bases, size codes and signedness, with width limits at both ends
    set_no       = 0;
    first_random = chars_sent;
    while (chars_sent - first_random < RANDOM_CHARS) begin
      case (set_no % 5)
        0:       width = '0;
        1:       width = 16'd1;
        2:       width = '1;
        default: width = count_t'($urandom_range(2, 12));
      endcase
      set_config(2'(set_no % 4), width, 3'(set_no % 8), 1'((set_no / 4) % 2));
      pace_on = (set_no % 6 != 5);
      repeat (FIELDS_PER_SET) random_field();
      send_eoi();
      set_no++;
    end

    // One unpaced field: leading spaces, a sign and a digit run that wraps the accumulator
    set_config(MODE_DEC, '1, SIZE_64, 1'b0);
    pace_on = 1'b0;
    repeat (LONG_SPACES) send_char(CH_SPACE);
    send_char(CH_MINUS);
    repeat (LONG_DIGITS) send_char(digit_char(7));
    send_eoi();
    settle();

    $display("Drove %0d characters and %0d register writes over %0d settings, incl. a %0d-char field",
             chars_sent, reg_writes, settings, LONG_SPACES + LONG_DIGITS + 1);
    $display("Checked %0d conversions, %0d of them failed parses, %0d mismatches",
             conversions, failed_parses, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### ascii_integer_field_parser.f
src/aifp_pkg.sv
src/aifp_if.sv
src/aifp_step.sv
src/aifp_format.sv
src/ascii_integer_field_parser.sv
tb/tb.sv
